### sv/ddo_pkg.sv
`default_nettype none
package ddo_pkg;

	localparam int TsW      = 64;
	localparam int CntW     = 16;
	localparam int IncW     = 16;
	localparam int CircW    = 20;
	localparam int OffW     = 19;
	localparam int BaseW    = 20;
	localparam int OutW     = 32;
	localparam int AccW     = 24;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 20;
	localparam int MulBW    = 20;
	localparam int DistW    = 43;
	localparam int DiffW    = 45;
	localparam int AngW     = 41;
	localparam int ZW       = 42;
	localparam int StepW    = 40;
	localparam int IterW    = 5;

	localparam logic [CfgIdxW-1:0] CFG_LEFT_INC   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_RIGHT_INC  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_LEFT_CIRC  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_RIGHT_CIRC = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_LEFT_OFF   = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_RIGHT_OFF  = 3'd5;

	localparam logic [MulBW-1:0] UsPerSec = 20'd1000000;
	localparam logic [StepW-1:0] PrPerRad = 40'd1000000000000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WL_MUL, ST_WL_DIV, ST_WR_MUL, ST_WR_DIV, ST_CL_MUL, ST_CR_MUL,
		ST_SUM, ST_C_DIV, ST_LIN_MUL, ST_LIN_DIV, ST_ANG_WAIT, ST_ANG_DIV, ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {CP_IDLE, CP_NORM, CP_ITER} cord_state_t;

	function automatic logic [AccW-1:0] sat24(logic [AccW-1:0] p, logic [CntW-1:0] d);
		logic [AccW:0] s;
		s = {p[AccW-1], p} + {{(AccW+1-CntW){d[CntW-1]}}, d};
		if (s[AccW] != s[AccW-1])
			return s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
		return s[AccW-1:0];
	endfunction

	function automatic logic [OutW-1:0] sat32(logic neg, logic [63:0] mag);
		logic [OutW-1:0] r;
		if (neg) begin
			if (mag > 64'h8000_0000) r = 32'h8000_0000;
			else r = ~mag[OutW-1:0] + 32'd1;
		end else begin
			if (mag > 64'h7fff_ffff) r = 32'h7fff_ffff;
			else r = mag[OutW-1:0];
		end
		return r;
	endfunction

	function automatic logic [StepW-1:0] atan_step(logic [IterW-1:0] i);
		logic [StepW-1:0] r;
		unique case (i)
			5'd0:    r = 40'd785398163397;
			5'd1:    r = 40'd463647609001;
			5'd2:    r = 40'd244978663127;
			5'd3:    r = 40'd124354994547;
			5'd4:    r = 40'd62418809996;
			5'd5:    r = 40'd31239833430;
			5'd6:    r = 40'd15623728620;
			5'd7:    r = 40'd7812341060;
			5'd8:    r = 40'd3906230132;
			5'd9:    r = 40'd1953122516;
			5'd10:   r = 40'd976562190;
			5'd11:   r = 40'd488281211;
			5'd12:   r = 40'd244140620;
			default: r = PrPerRad >> i;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/differential_drive_odometry_unit.sv
// channel | direction | handshake            | payload
// in      | sink      | in_valid / in_stall  | timestamp_us, left/right_count_delta
// out     | source    | out_valid / out_stall| linear_speed_um_s, angular_speed_urad_s
// cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// stale sample (timestamp not later than the last): absorbed into the pending counts, no result
// fresh sample: out_valid follows five 64-step divider passes
// and five 20-step multiplier passes; cordic overlaps
// zero increments skip that wheel's divide; zero wheel base skips the arithmetic and gives a zero result
// reset: config registers to 1, timestamp and pending counts to 0, no result pending
// a result held by out_stall does not block the next input beat
`default_nettype none
module differential_drive_odometry_unit #(
	parameter int CORDIC_ITERATIONS = 24
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [ddo_pkg::TsW-1:0]           timestamp_us,
	input  wire logic signed [ddo_pkg::CntW-1:0]   left_count_delta,
	input  wire logic signed [ddo_pkg::CntW-1:0]   right_count_delta,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [ddo_pkg::OutW-1:0]        linear_speed_um_s,
	output logic signed [ddo_pkg::OutW-1:0]        angular_speed_urad_s,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ddo_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire logic [ddo_pkg::CfgDataW-1:0]      cfg_data
);
	import ddo_pkg::*;

	seq_state_t state_q, state_d;
	logic       entry_q, out_valid_q;

	logic [IncW-1:0]  linc_q, rinc_q;
	logic [CircW-1:0] lcirc_q, rcirc_q;
	logic [OffW-1:0]  loff_q, roff_q;
	logic [TsW-1:0]   last_ts_q;
	logic [AccW-1:0]  pend_l_q, pend_r_q;

	logic [AccW-1:0]  cl_q, cr_q;
	logic [TsW-1:0]   dt_q;
	logic             zero_q;
	logic [DistW-1:0] dl_mag_q, dr_mag_q, center_q;
	logic [63:0]      p1_q, s_q;
	logic [DiffW-1:0] diff_q;
	logic [OutW-1:0]  lin_q, lin_out_q, ang_out_q;

	logic             in_accept, stale, out_free;
	logic [AccW-1:0]  cl_new, cr_new, cl_mag, cr_mag;
	logic [BaseW-1:0] base;
	logic [63:0]      s_new, s_mag;
	logic [DiffW-1:0] dl_s, dr_s, diff_new, diff_mag;

	logic             mul_start, mul_done, div_start, div_done, cord_start, cord_busy;
	logic [63:0]      mul_a, mul_prod, div_num, div_den, div_quo;
	logic [MulBW-1:0] mul_b;
	logic [AngW-1:0]  cord_ang;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cl_new   = sat24(pend_l_q, left_count_delta);
		cr_new   = sat24(pend_r_q, right_count_delta);
		stale    = (timestamp_us <= last_ts_q);
		base     = BaseW'(loff_q) + BaseW'(roff_q);
		cl_mag   = cl_q[AccW-1] ? (~cl_q + 1'b1) : cl_q;
		cr_mag   = cr_q[AccW-1] ? (~cr_q + 1'b1) : cr_q;
		// signed sum of the two weighted distances
		s_new    = (p1_q ^ {64{cl_q[AccW-1]}}) + (mul_prod ^ {64{cr_q[AccW-1]}})
		         + 64'(cl_q[AccW-1]) + 64'(cr_q[AccW-1]);
		s_mag    = s_q[63] ? (~s_q + 64'd1) : s_q;
		dl_s     = cl_q[AccW-1] ? (~DiffW'(dl_mag_q) + 1'b1) : DiffW'(dl_mag_q);
		dr_s     = cr_q[AccW-1] ? (~DiffW'(dr_mag_q) + 1'b1) : DiffW'(dr_mag_q);
		diff_new = dr_s - dl_s;
		diff_mag = diff_q[DiffW-1] ? (~diff_q + 1'b1) : diff_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_accept && !stale)
				state_d = (base == '0) ? ST_DONE : ST_WL_MUL;
			ST_WL_MUL:   if (mul_done) state_d = (linc_q == '0) ? ST_WR_MUL : ST_WL_DIV;
			ST_WL_DIV:   if (div_done) state_d = ST_WR_MUL;
			ST_WR_MUL:   if (mul_done) state_d = (rinc_q == '0) ? ST_CL_MUL : ST_WR_DIV;
			ST_WR_DIV:   if (div_done) state_d = ST_CL_MUL;
			ST_CL_MUL:   if (mul_done) state_d = ST_CR_MUL;
			ST_CR_MUL:   if (mul_done) state_d = ST_SUM;
			ST_SUM:      state_d = ST_C_DIV;
			ST_C_DIV:    if (div_done) state_d = ST_LIN_MUL;
			ST_LIN_MUL:  if (mul_done) state_d = ST_LIN_DIV;
			ST_LIN_DIV:  if (div_done) state_d = ST_ANG_WAIT;
			ST_ANG_WAIT: if (!cord_busy) state_d = ST_ANG_DIV;
			ST_ANG_DIV:  if (div_done) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mul_start  = 1'b0;
		div_start  = 1'b0;
		cord_start = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		div_num    = '0;
		div_den    = '0;
		unique case (state_q)
			ST_WL_MUL: begin
				mul_start = entry_q;
				mul_a     = 64'(cl_mag);
				mul_b     = lcirc_q;
			end
			ST_WR_MUL: begin
				mul_start = entry_q;
				mul_a     = 64'(cr_mag);
				mul_b     = rcirc_q;
			end
			ST_CL_MUL: begin
				mul_start = entry_q;
				mul_a     = 64'(dl_mag_q);
				mul_b     = MulBW'(loff_q);
			end
			ST_CR_MUL: begin
				mul_start = entry_q;
				mul_a     = 64'(dr_mag_q);
				mul_b     = MulBW'(roff_q);
			end
			ST_LIN_MUL: begin
				mul_start = entry_q;
				mul_a     = 64'(center_q);
				mul_b     = UsPerSec;
			end
			ST_WL_DIV: begin
				div_start = entry_q;
				div_num   = mul_prod;
				div_den   = 64'(linc_q);
			end
			ST_WR_DIV: begin
				div_start = entry_q;
				div_num   = mul_prod;
				div_den   = 64'(rinc_q);
			end
			ST_C_DIV: begin
				div_start  = entry_q;
				cord_start = entry_q;
				div_num    = s_mag;
				div_den    = 64'(base);
			end
			ST_LIN_DIV: begin
				div_start = entry_q;
				div_num   = mul_prod;
				div_den   = dt_q;
			end
			ST_ANG_DIV: begin
				div_start = entry_q;
				div_num   = 64'(cord_ang);
				div_den   = dt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			entry_q     <= 1'b0;
			out_valid_q <= 1'b0;
			linc_q      <= IncW'(1);
			rinc_q      <= IncW'(1);
			lcirc_q     <= CircW'(1);
			rcirc_q     <= CircW'(1);
			loff_q      <= OffW'(1);
			roff_q      <= OffW'(1);
			last_ts_q   <= '0;
			pend_l_q    <= '0;
			pend_r_q    <= '0;
		end else begin
			state_q <= state_d;
			entry_q <= (state_d != state_q);
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LEFT_INC:   linc_q  <= cfg_data[IncW-1:0];
					CFG_RIGHT_INC:  rinc_q  <= cfg_data[IncW-1:0];
					CFG_LEFT_CIRC:  lcirc_q <= cfg_data[CircW-1:0];
					CFG_RIGHT_CIRC: rcirc_q <= cfg_data[CircW-1:0];
					CFG_LEFT_OFF:   loff_q  <= cfg_data[OffW-1:0];
					CFG_RIGHT_OFF:  roff_q  <= cfg_data[OffW-1:0];
					default: ;
				endcase
			end
			if (in_accept) begin
				if (stale) begin
					pend_l_q <= cl_new;
					pend_r_q <= cr_new;
				end else begin
					last_ts_q <= timestamp_us;
					pend_l_q  <= '0;
					pend_r_q  <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cl_q   <= cl_new;
			cr_q   <= cr_new;
			dt_q   <= timestamp_us - last_ts_q;
			zero_q <= (base == '0);
		end
		if (state_q == ST_WL_MUL && mul_done && linc_q == '0) dl_mag_q <= '0;
		if (state_q == ST_WL_DIV && div_done) dl_mag_q <= div_quo[DistW-1:0];
		if (state_q == ST_WR_MUL && mul_done && rinc_q == '0) dr_mag_q <= '0;
		if (state_q == ST_WR_DIV && div_done) dr_mag_q <= div_quo[DistW-1:0];
		if (state_q == ST_CL_MUL && mul_done) p1_q <= mul_prod;
		if (state_q == ST_SUM) begin
			s_q    <= s_new;
			diff_q <= diff_new;
		end
		if (state_q == ST_C_DIV && div_done) center_q <= div_quo[DistW-1:0];
		if (state_q == ST_LIN_DIV && div_done) lin_q <= sat32(s_q[63], div_quo);
		if (state_q == ST_DONE && out_free) begin
			lin_out_q <= zero_q ? '0 : lin_q;
			ang_out_q <= zero_q ? '0 : sat32(diff_q[DiffW-1], div_quo);
		end
	end

	ddo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a_in   (mul_a),
		.b_in   (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ddo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_in (div_num),
		.den_in (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	ddo_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.num_in (64'(diff_mag[DiffW-2:0])),
		.den_in (64'(base)),
		.busy   (cord_busy),
		.ang    (cord_ang)
	);

	assign out_valid            = out_valid_q;
	assign linear_speed_um_s    = lin_out_q;
	assign angular_speed_urad_s = ang_out_q;
endmodule
`default_nettype wire

### sv/ddo_mul.sv
`default_nettype none
module ddo_mul (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [63:0]              a_in,
	input  wire logic [ddo_pkg::MulBW-1:0] b_in,
	output logic                          done,
	output logic [63:0]                   prod
);
	import ddo_pkg::*;

	localparam int CW = $clog2(MulBW);

	logic [63:0]       a_q, acc_q;
	logic [MulBW-1:0]  b_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MulBW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one multiplier bit per cycle, lsb first
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a_in;
			b_q   <= b_in;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (b_q[0] ? a_q : 64'd0);
			a_q   <= {a_q[62:0], 1'b0};
			b_q   <= {1'b0, b_q[MulBW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

### sv/ddo_div.sv
`default_nettype none
module ddo_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num_in,
	input  wire logic [63:0] den_in,
	output logic             done,
	output logic [63:0]      quo
);
	logic [63:0] quo_q, rem_q, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] shifted, trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quo_q[63]};
		trial   = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num_in;
			den_q <= den_in;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### sv/ddo_cordic.sv
`default_nettype none
module ddo_cordic #(
	parameter int ITERATIONS = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [63:0]             num_in,
	input  wire logic [63:0]             den_in,
	output logic                         busy,
	output logic [ddo_pkg::AngW-1:0]     ang
);
	import ddo_pkg::*;

	localparam int NIter = (ITERATIONS > 32) ? 32 : ITERATIONS;
	localparam logic [IterW-1:0] LastIter = IterW'(NIter - 1);

	cord_state_t state_q, state_d;
	logic signed [63:0]  x_q, y_q;
	logic [63:0]         m_q;
	logic signed [ZW-1:0] z_q;
	logic [IterW-1:0]    i_q;
	logic signed [63:0]  xs, ys;
	logic signed [ZW-1:0] step;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CP_IDLE: if (start && num_in != 64'd0) state_d = CP_NORM;
			CP_NORM: if (m_q[63:59] != 5'd0) state_d = CP_ITER;
			CP_ITER: if (i_q == LastIter) state_d = CP_IDLE;
			default: state_d = CP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CP_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		xs   = x_q >>> i_q;
		ys   = y_q >>> i_q;
		step = ZW'(atan_step(i_q));
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			CP_IDLE: if (start) begin
				x_q <= den_in;
				y_q <= num_in;
				m_q <= (num_in > den_in) ? num_in : den_in;
				z_q <= '0;
				i_q <= '0;
			end
			CP_NORM: begin
				// bring the larger operand up to bit 59
				if (m_q[63:55] == 9'd0) begin
					x_q <= x_q <<< 4;
					y_q <= y_q <<< 4;
					m_q <= m_q << 4;
				end else if (m_q[63:59] == 5'd0) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
					m_q <= m_q << 1;
				end
			end
			CP_ITER: begin
				if (!y_q[63]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + step;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - step;
				end
				i_q <= i_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != CP_IDLE);
	assign ang  = z_q[ZW-1] ? '0 : z_q[AngW-1:0];
endmodule
`default_nettype wire

### test/differential_drive_odometry_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module differential_drive_odometry_unit_tb;
	import ddo_pkg::*;

	localparam int Iters = 24;
	localparam int Settle = 600;
	localparam longint unsigned CycleLimit = 6000000;

	typedef struct {
		logic signed [OutW-1:0] lin;
		logic signed [OutW-1:0] ang;
	} speed_t;

	typedef struct {
		logic [TsW-1:0] ts;
		logic signed [CntW-1:0] l;
		logic signed [CntW-1:0] r;
		bit typed;
		logic signed [OutW-1:0] lin;
		logic signed [OutW-1:0] ang;
	} sample_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	logic [TsW-1:0] timestamp_us;
	logic signed [CntW-1:0] left_count_delta, right_count_delta;
	logic signed [OutW-1:0] linear_speed_um_s, angular_speed_urad_s;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	differential_drive_odometry_unit #(.CORDIC_ITERATIONS(Iters)) uut (.*);

	// predictor copy of the block's registers and state
	longint unsigned inc_l, inc_r, circ_l, circ_r, off_l, off_r;
	logic [TsW-1:0] prev_ts;
	longint pend_l, pend_r;

	speed_t speed_q[$];
	int errors = 0;
	int gap_pct = 0, stall_pct = 0;
	longint unsigned cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_stall <= ($urandom_range(99) < stall_pct);
		if (cycles > CycleLimit) begin
			$display("[differential_drive_odometry_unit] ERROR");
			$finish;
		end
	end

	function automatic longint clamp24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic logic [OutW-1:0] clamp_out(bit neg, logic [63:0] mag);
		if (neg) return (mag > 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
		return (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
	endfunction

	function automatic longint wheel_travel(longint counts, longint unsigned circ,
			longint unsigned inc);
		longint unsigned m;
		if (inc == 0) return 0;
		m = ((counts < 0) ? -counts : counts) * circ / inc;
		return (counts < 0) ? -longint'(m) : longint'(m);
	endfunction

	// arctangent of num/den in picoradians, vectoring mode
	function automatic logic [63:0] yaw_pr(logic [63:0] num, logic [63:0] den);
		logic [63:0] atan_lut [13] = '{64'd785398163397, 64'd463647609001,
			64'd244978663127, 64'd124354994547, 64'd62418809996, 64'd31239833430,
			64'd15623728620, 64'd7812341060, 64'd3906230132, 64'd1953122516,
			64'd976562190, 64'd488281211, 64'd244140620};
		logic [63:0] m, inc;
		longint x, y, z, nx;
		if (num == 0) return 0;
		m = (num > den) ? num : den;
		while (m < (64'd1 << 59)) begin
			m = m << 1; num = num << 1; den = den << 1;
		end
		x = den; y = num; z = 0;
		for (int i = 0; i < Iters; i++) begin
			inc = (i < 13) ? atan_lut[i] : (64'd1000000000000 >> i);
			if (y >= 0) begin
				nx = x + (y >>> i); y = y - (x >>> i); z = z + longint'(inc);
			end else begin
				nx = x - (y >>> i); y = y + (x >>> i); z = z - longint'(inc);
			end
			x = nx;
		end
		return (z < 0) ? 64'd0 : z;
	endfunction

	function automatic bit odometry_step(logic [TsW-1:0] ts, logic signed [CntW-1:0] l,
			logic signed [CntW-1:0] r, output speed_t s);
		longint cl, cr, dl, dr, center, diff;
		logic [63:0] dt, base;
		cl = clamp24(pend_l + l);
		cr = clamp24(pend_r + r);
		s = '{0, 0};
		if (ts <= prev_ts) begin
			pend_l = cl; pend_r = cr;
			return 0;
		end
		dt = ts - prev_ts;
		prev_ts = ts;
		pend_l = 0; pend_r = 0;
		base = off_l + off_r;
		if (base == 0) return 1;
		dl = wheel_travel(cl, circ_l, inc_l);
		dr = wheel_travel(cr, circ_r, inc_r);
		center = (longint'(off_l) * dl + longint'(off_r) * dr) / longint'(base);
		s.lin = clamp_out(center < 0, ((center < 0) ? -center : center) * 64'd1000000 / dt);
		diff = dr - dl;
		s.ang = clamp_out(diff < 0, yaw_pr((diff < 0) ? -diff : diff, base) / dt);
		return 1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("mismatch %s: expected %0d got %0d at cycle %0d",
			what, $signed(want), $signed(got), cycles);
		errors++;
	endtask

	always @(posedge clk) begin
		speed_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (speed_q.size() == 0) begin
				report_mismatch("unexpected beat", 0, linear_speed_um_s);
			end else begin
				e = speed_q.pop_front();
				if (linear_speed_um_s !== e.lin)
					report_mismatch("linear_speed_um_s", e.lin, linear_speed_um_s);
				if (angular_speed_urad_s !== e.ang)
					report_mismatch("angular_speed_urad_s", e.ang, angular_speed_urad_s);
			end
		end
	end

	task automatic send_sample(logic [TsW-1:0] ts, logic signed [CntW-1:0] l,
			logic signed [CntW-1:0] r, bit typed = 0, speed_t want = '{0, 0});
		speed_t s;
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid <= 1'b1;
		timestamp_us <= ts;
		left_count_delta <= l;
		right_count_delta <= r;
		do @(posedge clk); while (in_stall);
		if (odometry_step(ts, l, r, s))
			speed_q.push_back(typed ? want : s);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (speed_q.size() != 0) @(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LEFT_INC:   inc_l = val[IncW-1:0];
			CFG_RIGHT_INC:  inc_r = val[IncW-1:0];
			CFG_LEFT_CIRC:  circ_l = val[CircW-1:0];
			CFG_RIGHT_CIRC: circ_r = val[CircW-1:0];
			CFG_LEFT_OFF:   off_l = val[OffW-1:0];
			CFG_RIGHT_OFF:  off_r = val[OffW-1:0];
			default: ;
		endcase
	endtask

	function automatic logic signed [CntW-1:0] rand_delta();
		case ($urandom_range(3))
			0: return CntW'($urandom);
			1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return $signed(16'($urandom_range(400))) - 16'sd200;
		endcase
	endfunction

	sample_row_t rows [] = '{
		'{64'd1, 16'sd1, 16'sd1, 1, 32'sd1000000, 32'sd0},
		'{64'd2, 16'sd0, 16'sd0, 1, 32'sd0, 32'sd0},
		'{64'd2, 16'sh7fff, 16'sh8000, 0, 0, 0},
		'{64'd0, 16'sd0, 16'sd0, 0, 0, 0},
		'{64'd3, 16'sd0, 16'sd0, 1, 32'sd0, 32'sh8000_0000},
		'{64'd4, 16'sh7fff, 16'sh7fff, 1, 32'sh7fff_ffff, 32'sd0},
		'{64'd5, 16'sh8000, 16'sh8000, 1, 32'sh8000_0000, 32'sd0},
		'{64'd6, -16'sd1, 16'sd1, 0, 0, 0},
		'{64'd1006, 16'sd300, 16'sd200, 0, 0, 0},
		'{64'd1007, 16'sh8000, 16'sh7fff, 0, 0, 0},
		'{64'd90000, 16'sd5, -16'sd7, 0, 0, 0}
	};

	initial begin
		logic [TsW-1:0] ts;
		logic [CfgDataW-1:0] v;
		arst_n = 1'b0;
		in_valid = 1'b0; cfg_valid = 1'b0;
		timestamp_us = '0; left_count_delta = '0; right_count_delta = '0;
		cfg_index = '0; cfg_data = '0;
		inc_l = 1; inc_r = 1; circ_l = 1; circ_r = 1; off_l = 1; off_r = 1;
		prev_ts = '0; pend_l = 0; pend_r = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_sample(rows[i].ts, rows[i].l, rows[i].r, rows[i].typed,
				'{rows[i].lin, rows[i].ang});
		ts = 64'd90000;

		for (int p = 0; p < 9; p++) begin
			drain();
			case (p)
				0: begin
					write_reg(CFG_LEFT_INC, 20'h0ffff); write_reg(CFG_RIGHT_INC, 20'h0ffff);
					write_reg(CFG_LEFT_CIRC, 20'd1000000); write_reg(CFG_RIGHT_CIRC, 20'd1000000);
					write_reg(CFG_LEFT_OFF, 20'd500000); write_reg(CFG_RIGHT_OFF, 20'd500000);
				end
				1: begin
					write_reg(CFG_LEFT_INC, 20'd1); write_reg(CFG_RIGHT_INC, 20'd1);
					write_reg(CFG_LEFT_OFF, 20'd0); write_reg(CFG_RIGHT_OFF, 20'd1);
					write_reg(3'd6, 20'hfffff); write_reg(3'd7, 20'h5a5a5);
				end
				2: begin
					// zero wheel base
					write_reg(CFG_LEFT_OFF, 20'd0); write_reg(CFG_RIGHT_OFF, 20'd0);
				end
				3: begin
					// zero increments on one wheel
					write_reg(CFG_LEFT_INC, 20'd0); write_reg(CFG_RIGHT_INC, 20'd1024);
					write_reg(CFG_LEFT_OFF, 20'd80000); write_reg(CFG_RIGHT_OFF, 20'd0);
				end
				default: begin
					for (int k = 0; k < 6; k++) begin
						v = CfgDataW'($urandom);
						if ($urandom_range(1)) v = CfgDataW'((k < 2) ? $urandom_range(4096, 1)
							: (k < 4) ? $urandom_range(1000000, 1000) : $urandom_range(500000));
						write_reg(k[CfgIdxW-1:0], v);
					end
				end
			endcase
			cfg_valid <= 1'b0;
			gap_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 58 : 17) : 0;
			stall_pct = (p % 4 == 2) ? 58 : (p % 4 == 3) ? 17 : 0;

			if (p == 5) begin
				// run the pending sums into saturation with stale beats
				for (int k = 0; k < 300; k++)
					send_sample(ts, (k < 150) ? 16'sh7fff : 16'sh8000,
						(k < 150) ? 16'sh8000 : 16'sh7fff);
			end

			for (int k = 0; k < 155; k++) begin
				if (p == 6 && k == 95) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (speed_q.size() != 0);
				end
				case ($urandom_range(19))
					0, 1: send_sample(ts - $urandom_range(3), rand_delta(), rand_delta());
					2: begin
						ts = ts + {$urandom, $urandom} % 64'h1_0000_0000;
						send_sample(ts, rand_delta(), rand_delta());
					end
					3: begin
						ts = ts + 1;
						send_sample(ts, rand_delta(), rand_delta());
					end
					default: begin
						ts = ts + $urandom_range(2000, 1);
						send_sample(ts, rand_delta(), rand_delta());
					end
				endcase
			end
		end

		send_sample(64'd0, rand_delta(), rand_delta());
		send_sample({TsW{1'b1}}, rand_delta(), rand_delta());
		drain();
		if (errors == 0)
			$display("[differential_drive_odometry_unit] OK");
		else
			$display("[differential_drive_odometry_unit] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
